@@ rtl/core/rcdr_pkg.sv @@
`default_nettype none

package rcdr_pkg;

  // field widths
  localparam int SAMPLE_BITS = 12;
  localparam int COUNT_BITS  = 16;
  localparam int WLEN_W      = 16;
  localparam int CAL_W       = 32;
  localparam int SHIFT_W     = 4;
  localparam int OSTART_W    = 12;
  localparam int IRMS_W      = 32;

  // fixed point positions
  localparam int OFFSET_FRAC = 16;
  localparam int KEEP_FRAC   = 4;
  localparam int Q4_SHIFT    = OFFSET_FRAC - KEEP_FRAC;
  localparam int CAL_FRAC    = 24;
  localparam int ROOT_PAD    = 2 * Q4_SHIFT;

  // datapath widths
  localparam int OFF_W       = SAMPLE_BITS + OFFSET_FRAC;
  localparam int DIFF_W      = OFF_W + 1;
  localparam int MAG_W       = DIFF_W - Q4_SHIFT;
  localparam int MEAN_W      = 2 * MAG_W - 1;
  localparam int SUM_W       = MEAN_W + COUNT_BITS;
  localparam int RAD_W       = MEAN_W + ((MEAN_W + ROOT_PAD) % 2);
  localparam int ROOT_W      = (RAD_W + ROOT_PAD) / 2;
  localparam int SQRT_REM_W  = ROOT_W + 1;
  localparam int CMP_W       = (COUNT_BITS > WLEN_W) ? COUNT_BITS : WLEN_W;

  // digit-serial squarer
  localparam int SQ_DIGIT    = 6;
  localparam int SQ_STEPS    = (MAG_W + SQ_DIGIT - 1) / SQ_DIGIT;
  localparam int SQ_MPLR_W   = SQ_DIGIT * SQ_STEPS;
  localparam int SQ_MCAND_W  = MAG_W + SQ_DIGIT * (SQ_STEPS - 1);
  localparam int SQ_CNT_W    = $clog2(SQ_STEPS);

  // iteration counters of the window units
  localparam int DIV_CNT_W   = $clog2(SUM_W);
  localparam int ROOT_CNT_W  = $clog2(ROOT_W);

  // stream words
  localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((IRMS_W + 7) / 8) * 8;

  // configuration port
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_LENGTH  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CAL_RATIO      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FILTER_SHIFT   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_RESTART_OFFSET = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_START   = 3'd4;

  localparam logic [WLEN_W-1:0]   WLEN_RESET    = 16'd1480;
  localparam logic [CAL_W-1:0]    CAL_RESET     = 32'd36700160;
  localparam logic [SHIFT_W-1:0]  SHIFT_RESET   = 4'd11;
  localparam logic                RESTART_RESET = 1'b1;
  localparam logic [OSTART_W-1:0] OSTART_RESET  = 12'd1024;

  // status of the sample front end toward the window sequencer
  typedef struct packed {
    logic ready;     // front end can take a sample this cycle
    logic win_done;  // window closed, sum and count wait for hand-off
  } front_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/rms_current_dc_removed_core.sv @@
`default_nettype none

// channel  | dir | ports                           | contents (lsb first)
// ---------+-----+---------------------------------+------------------------------
// in       | in  | in_tvalid/in_tready/in_tdata    | sample[11:0], zero pad
// out      | out | out_tvalid/out_tready/out_tdata | irms[31:0] (Q16.16)
//          |     | out_tuser                       | saturated
// cfg      | in  | cfg_we/cfg_addr/cfg_wdata       | register index, write data
//
// a sample is taken and sample minus offset formed, then the low-pass step,
// then three 6-bit digits of the squarer; back to back, the next sample is
// taken with the last digit; closing a window runs the divider, the root and
// the shift-add multiplier in turn; the front end accumulates the next window
// meanwhile and stalls only when that one closes before the previous result
// is loaded into the output register; synchronous active-low reset, no clearing pass

module rms_current_dc_removed_core (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // sample stream
  input  wire                                   in_tvalid,
  output logic                                  in_tready,
  input  wire  [rcdr_pkg::IN_TDATA_W-1:0]       in_tdata,   // sample, zero pad
  // result stream
  output logic                                  out_tvalid,
  input  wire                                   out_tready,
  output logic [rcdr_pkg::OUT_TDATA_W-1:0]      out_tdata,  // irms
  output logic [0:0]                            out_tuser,  // saturated
  // configuration writes
  input  wire                                   cfg_we,
  input  wire  [rcdr_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  wire  [rcdr_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int SAMPLE_BITS = rcdr_pkg::SAMPLE_BITS;
  localparam int WLEN_W      = rcdr_pkg::WLEN_W;
  localparam int CAL_W       = rcdr_pkg::CAL_W;
  localparam int SHIFT_W     = rcdr_pkg::SHIFT_W;
  localparam int OSTART_W    = rcdr_pkg::OSTART_W;
  localparam int IRMS_W      = rcdr_pkg::IRMS_W;
  localparam int OUT_TDATA_W = rcdr_pkg::OUT_TDATA_W;

  // window sequencer states
  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_DIV  = 3'd1;
  localparam logic [2:0] B_SQRT = 3'd2;
  localparam logic [2:0] B_MUL  = 3'd3;
  localparam logic [2:0] B_OUT  = 3'd4;

  // configuration registers
  logic [WLEN_W-1:0]   wlen_r;
  logic [CAL_W-1:0]    cal_r;
  logic [SHIFT_W-1:0]  shift_r;
  logic                restart_r;
  logic [OSTART_W-1:0] ostart_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r    <= rcdr_pkg::WLEN_RESET;
      cal_r     <= rcdr_pkg::CAL_RESET;
      shift_r   <= rcdr_pkg::SHIFT_RESET;
      restart_r <= rcdr_pkg::RESTART_RESET;
      ostart_r  <= rcdr_pkg::OSTART_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        rcdr_pkg::REG_WINDOW_LENGTH:  wlen_r    <= cfg_wdata[WLEN_W-1:0];
        rcdr_pkg::REG_CAL_RATIO:      cal_r     <= cfg_wdata[CAL_W-1:0];
        rcdr_pkg::REG_FILTER_SHIFT:   shift_r   <= cfg_wdata[SHIFT_W-1:0];
        rcdr_pkg::REG_RESTART_OFFSET: restart_r <= cfg_wdata[0];
        rcdr_pkg::REG_OFFSET_START:   ostart_r  <= cfg_wdata[OSTART_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // sample front end: offset low-pass, serial square and accumulate
  rcdr_pkg::front_stat_t                fstat;
  logic                                 front_ack;
  logic [rcdr_pkg::SUM_W-1:0]           win_sum;
  logic [rcdr_pkg::COUNT_BITS-1:0]      win_count;

  rcdr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_sample (in_tdata[SAMPLE_BITS-1:0]),
    .stat      (fstat),
    .win_ack   (front_ack),
    .wlen      (wlen_r),
    .shift     (shift_r),
    .restart   (restart_r),
    .ostart    (ostart_r),
    .sum       (win_sum),
    .count     (win_count)
  );

  assign in_tready = fstat.ready;

  // window units, run one after the other
  logic [2:0]                      bst_r, bst_nxt;
  logic                            div_start, div_done;
  logic                            sqrt_start, sqrt_done;
  logic                            mul_start, mul_done;
  logic [rcdr_pkg::MEAN_W-1:0]     mean;
  logic [rcdr_pkg::ROOT_W-1:0]     root;
  logic [IRMS_W-1:0]               irms;
  logic                            sat;
  logic                            out_load;

  rcdr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (win_sum),
    .divisor  (win_count),
    .done     (div_done),
    .quot     (mean)
  );

  rcdr_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .mean  (mean),
    .done  (sqrt_done),
    .root  (root)
  );

  rcdr_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .root  (root),
    .cal   (cal_r),
    .done  (mul_done),
    .irms  (irms),
    .sat   (sat)
  );

  // output register, reloaded once the previous word is taken
  logic                  out_valid_r;
  logic [IRMS_W-1:0]     out_irms_r;
  logic                  out_sat_r;

  always_comb begin
    // the divider latches sum and count on start, so the front end is
    // released in the same cycle
    front_ack  = (bst_r == B_IDLE) && fstat.win_done;
    div_start  = front_ack;
    sqrt_start = (bst_r == B_DIV) && div_done;
    mul_start  = (bst_r == B_SQRT) && sqrt_done;
    out_load   = (bst_r == B_OUT) && (!out_valid_r || out_tready);
  end

  always_comb begin
    bst_nxt = bst_r;
    case (bst_r)
      B_IDLE: if (front_ack) bst_nxt = B_DIV;
      B_DIV:  if (div_done)  bst_nxt = B_SQRT;
      B_SQRT: if (sqrt_done) bst_nxt = B_MUL;
      B_MUL:  if (mul_done)  bst_nxt = B_OUT;
      B_OUT:  if (out_load)  bst_nxt = B_IDLE;
      default: bst_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bst_r       <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      bst_r <= bst_nxt;
      if (out_load)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_irms_r <= irms;
      out_sat_r  <= sat;
    end
  end

  always_comb begin
    out_tvalid   = out_valid_r;
    out_tdata    = OUT_TDATA_W'(out_irms_r);
    out_tuser[0] = out_sat_r;
  end

`ifndef SYNTHESIS
  a_sat_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_sat_r |-> (out_irms_r == {IRMS_W{1'b1}}))
    else $error("saturated word is not full scale");

  a_hold_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    fstat.win_done |-> !fstat.ready)
    else $error("front end takes samples while a window waits");
`endif

endmodule

`default_nettype wire

@@ rtl/core/rcdr_front.sv @@
`default_nettype none

module rcdr_front (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    in_valid,
  input  wire  [rcdr_pkg::SAMPLE_BITS-1:0]       in_sample,
  output rcdr_pkg::front_stat_t                  stat,
  input  wire                                    win_ack,
  input  wire  [rcdr_pkg::WLEN_W-1:0]            wlen,
  input  wire  [rcdr_pkg::SHIFT_W-1:0]           shift,
  input  wire                                    restart,
  input  wire  [rcdr_pkg::OSTART_W-1:0]          ostart,
  output logic [rcdr_pkg::SUM_W-1:0]             sum,
  output logic [rcdr_pkg::COUNT_BITS-1:0]        count
);

  localparam int SAMPLE_BITS = rcdr_pkg::SAMPLE_BITS;
  localparam int COUNT_BITS  = rcdr_pkg::COUNT_BITS;
  localparam int OFF_W       = rcdr_pkg::OFF_W;
  localparam int DIFF_W      = rcdr_pkg::DIFF_W;
  localparam int MAG_W       = rcdr_pkg::MAG_W;
  localparam int SUM_W       = rcdr_pkg::SUM_W;
  localparam int CMP_W       = rcdr_pkg::CMP_W;
  localparam int OFFSET_FRAC = rcdr_pkg::OFFSET_FRAC;
  localparam int Q4_SHIFT    = rcdr_pkg::Q4_SHIFT;
  localparam int SQ_DIGIT    = rcdr_pkg::SQ_DIGIT;
  localparam int SQ_STEPS    = rcdr_pkg::SQ_STEPS;
  localparam int SQ_MPLR_W   = rcdr_pkg::SQ_MPLR_W;
  localparam int SQ_MCAND_W  = rcdr_pkg::SQ_MCAND_W;
  localparam int SQ_CNT_W    = rcdr_pkg::SQ_CNT_W;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_UPD  = 2'd1;
  localparam logic [1:0] F_SQ   = 2'd2;
  localparam logic [1:0] F_HOLD = 2'd3;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [1:0]                    st_r, st_nxt;
  logic [OFF_W-1:0]              off_r;
  logic signed [DIFF_W-1:0]      d_r;
  logic [COUNT_BITS-1:0]         cnt_r, wcnt_r;
  logic                          close_r;
  logic [SUM_W-1:0]              sum_r;
  logic [SQ_MCAND_W-1:0]         mcand_r;
  logic [SQ_MPLR_W-1:0]          mplr_r;
  logic [SQ_CNT_W-1:0]           sqc_r;

  logic                          sq_last, ready, accept, close;
  logic [COUNT_BITS-1:0]         cnt_inc;
  logic [OFF_W-1:0]              s16, base;
  logic signed [DIFF_W-1:0]      d_new, step, diff;
  logic [MAG_W-1:0]              q4, mag;
  logic [SQ_MCAND_W+SQ_DIGIT-1:0] pp;

  always_comb begin
    sq_last = (sqc_r == SQ_CNT_W'(SQ_STEPS - 1));
    ready   = (st_r == F_IDLE) || ((st_r == F_SQ) && sq_last && !close_r);
    accept  = in_valid && ready;
    cnt_inc = cnt_r + 1'b1;
    // window closes at its length or when the count saturates
    close   = (CMP_W'(cnt_inc) >= CMP_W'(wlen)) || (cnt_inc == COUNT_MAX);
    s16     = {in_sample, {OFFSET_FRAC{1'b0}}};
    base    = (restart && (cnt_r == '0)) ?
              {SAMPLE_BITS'(ostart), {OFFSET_FRAC{1'b0}}} : off_r;
    d_new   = $signed({1'b0, s16}) - $signed({1'b0, base});
    // low-pass step floors; sample minus new offset is d minus step
    step    = d_r >>> shift;
    diff    = d_r - step;
    q4      = diff[DIFF_W-1:Q4_SHIFT];
    mag     = q4[MAG_W-1] ? (~q4 + 1'b1) : q4;
    pp      = mcand_r * mplr_r[SQ_DIGIT-1:0];
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      F_IDLE: if (accept) st_nxt = F_UPD;
      F_UPD:  st_nxt = F_SQ;
      F_SQ: begin
        if (sq_last) begin
          if (close_r)     st_nxt = F_HOLD;
          else if (accept) st_nxt = F_UPD;
          else             st_nxt = F_IDLE;
        end
      end
      F_HOLD: if (win_ack) st_nxt = F_IDLE;
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= F_IDLE;
      off_r   <= {SAMPLE_BITS'(rcdr_pkg::OSTART_RESET), {OFFSET_FRAC{1'b0}}};
      cnt_r   <= '0;
      close_r <= 1'b0;
      sum_r   <= '0;
      sqc_r   <= '0;
    end else begin
      st_r <= st_nxt;
      if (accept) begin
        off_r   <= base;
        cnt_r   <= close ? '0 : cnt_inc;
        close_r <= close;
      end
      if (st_r == F_UPD) begin
        off_r <= off_r + step[OFF_W-1:0];
        sqc_r <= '0;
      end
      if (st_r == F_SQ) begin
        sum_r <= sum_r + SUM_W'(pp);
        sqc_r <= sqc_r + 1'b1;
      end
      if ((st_r == F_HOLD) && win_ack) sum_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      d_r    <= d_new;
      wcnt_r <= cnt_inc;
    end
    if (st_r == F_UPD) begin
      mcand_r <= SQ_MCAND_W'(mag);
      mplr_r  <= SQ_MPLR_W'(mag);
    end else if (st_r == F_SQ) begin
      mcand_r <= mcand_r << SQ_DIGIT;
      mplr_r  <= mplr_r >> SQ_DIGIT;
    end
  end

  always_comb begin
    stat.ready    = ready;
    stat.win_done = (st_r == F_HOLD);
    sum           = sum_r;
    count         = wcnt_r;
  end

`ifndef SYNTHESIS
  a_cnt_below_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != COUNT_MAX)
    else $error("sample count reached its maximum without closing");

  a_close_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == F_SQ) && sq_last && close_r |=> (st_r == F_HOLD) && !stat.ready)
    else $error("closing sample did not stop the front end");

  a_sum_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == F_HOLD) && win_ack |=> (sum_r == '0) && (cnt_r == '0))
    else $error("window hand-off left sum or count behind");
`endif

endmodule

`default_nettype wire

@@ rtl/core/rcdr_div.sv @@
`default_nettype none

module rcdr_div (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  input  wire  [rcdr_pkg::SUM_W-1:0]       dividend,
  input  wire  [rcdr_pkg::COUNT_BITS-1:0]  divisor,
  output logic                             done,
  output logic [rcdr_pkg::MEAN_W-1:0]      quot
);

  localparam int SUM_W      = rcdr_pkg::SUM_W;
  localparam int COUNT_BITS = rcdr_pkg::COUNT_BITS;
  localparam int MEAN_W     = rcdr_pkg::MEAN_W;
  localparam int DIV_CNT_W  = rcdr_pkg::DIV_CNT_W;

  logic [SUM_W-1:0]      q_r;
  logic [COUNT_BITS-1:0] rem_r, dv_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic                  busy_r, done_r;

  logic [COUNT_BITS:0]   t, tsub;
  logic                  ge;

  // restoring division, one quotient bit a cycle
  always_comb begin
    t    = {rem_r, q_r[SUM_W-1]};
    ge   = (t >= {1'b0, dv_r});
    tsub = t - {1'b0, dv_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(SUM_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dv_r  <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[SUM_W-2:0], ge};
      rem_r <= ge ? tsub[COUNT_BITS-1:0] : t[COUNT_BITS-1:0];
    end
  end

  always_comb begin
    done = done_r;
    quot = q_r[MEAN_W-1:0];
  end

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r < dv_r))
    else $error("partial remainder not below divisor");
`endif

endmodule

`default_nettype wire

@@ rtl/core/rcdr_sqrt.sv @@
`default_nettype none

module rcdr_sqrt (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            start,
  input  wire  [rcdr_pkg::MEAN_W-1:0]    mean,
  output logic                           done,
  output logic [rcdr_pkg::ROOT_W-1:0]    root
);

  localparam int MEAN_W     = rcdr_pkg::MEAN_W;
  localparam int RAD_W      = rcdr_pkg::RAD_W;
  localparam int ROOT_W     = rcdr_pkg::ROOT_W;
  localparam int SQRT_REM_W = rcdr_pkg::SQRT_REM_W;
  localparam int ROOT_CNT_W = rcdr_pkg::ROOT_CNT_W;

  logic [RAD_W-1:0]      rad_r;
  logic [SQRT_REM_W-1:0] rem_r;
  logic [ROOT_W-1:0]     root_r;
  logic [ROOT_CNT_W-1:0] cnt_r;
  logic                  busy_r, done_r;

  logic [SQRT_REM_W+1:0] t, trial, tsub;
  logic                  ge;

  // one root bit per cycle from two radicand bits; the zero fraction
  // bits of the radicand shift in behind the mean
  always_comb begin
    t     = {rem_r, rad_r[RAD_W-1 -: 2]};
    trial = (SQRT_REM_W + 2)'({root_r, 2'b01});
    ge    = (t >= trial);
    tsub  = t - trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= ROOT_CNT_W'(ROOT_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= RAD_W'(mean);
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= rad_r << 2;
      rem_r  <= ge ? tsub[SQRT_REM_W-1:0] : t[SQRT_REM_W-1:0];
      root_r <= {root_r[ROOT_W-2:0], ge};
    end
  end

  always_comb begin
    done = done_r;
    root = root_r;
  end

endmodule

`default_nettype wire

@@ rtl/core/rcdr_mul.sv @@
`default_nettype none

module rcdr_mul (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            start,
  input  wire  [rcdr_pkg::ROOT_W-1:0]    root,
  input  wire  [rcdr_pkg::CAL_W-1:0]     cal,
  output logic                           done,
  output logic [rcdr_pkg::IRMS_W-1:0]    irms,
  output logic                           sat
);

  localparam int ROOT_W     = rcdr_pkg::ROOT_W;
  localparam int CAL_W      = rcdr_pkg::CAL_W;
  localparam int CAL_FRAC   = rcdr_pkg::CAL_FRAC;
  localparam int IRMS_W     = rcdr_pkg::IRMS_W;
  localparam int ROOT_CNT_W = rcdr_pkg::ROOT_CNT_W;
  localparam int PROD_W     = CAL_W + ROOT_W;

  logic [CAL_W-1:0]      hi_r, cal_r;
  logic [ROOT_W-1:0]     lo_r;
  logic [ROOT_CNT_W-1:0] cnt_r;
  logic                  busy_r, done_r;

  logic [CAL_W:0]        addv;
  logic [PROD_W-1:0]     prod;

  // shift-add, root bits from the lsb up; the product builds in hi:lo
  always_comb begin
    addv = {1'b0, hi_r} + {1'b0, (lo_r[0] ? cal_r : {CAL_W{1'b0}})};
    prod = {hi_r, lo_r};
    sat  = |prod[PROD_W-1:CAL_FRAC+IRMS_W];
    irms = sat ? {IRMS_W{1'b1}} : prod[CAL_FRAC+IRMS_W-1:CAL_FRAC];
    done = done_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= ROOT_CNT_W'(ROOT_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hi_r  <= '0;
      lo_r  <= root;
      cal_r <= cal;
    end else if (busy_r) begin
      hi_r <= addv[CAL_W:1];
      lo_r <= {addv[0], lo_r[ROOT_W-1:1]};
    end
  end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rcdr_pkg::*;

  // run shape
  localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_WORDS   = 50;
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES   = 320;   // long receiver hold-off
  localparam int QUIET_LIMIT   = 3000;  // cycles with no word moving on the sample or result stream

  // one expected result word
  typedef struct packed {
    logic [IRMS_W-1:0] irms;
    logic              saturated;
  } irms_word_t;

  // tracks the block's filter and window state and checks result words
  class irms_scoreboard;
    bit [WLEN_W-1:0]     window_length;
    bit [CAL_W-1:0]      cal_ratio;
    bit [SHIFT_W-1:0]    filter_shift;
    bit                  restart_offset;
    bit [OSTART_W-1:0]   offset_start;
    longint              dc_offset;     // q.16
    longint unsigned     square_sum;    // q.8
    bit [COUNT_BITS-1:0] sample_count;
    irms_word_t          irms_expected[$];
    int                  errors;
    int                  samples_seen;
    int                  windows_closed;
    int                  saturated_seen;

    function new();
      window_length  = WLEN_RESET;
      cal_ratio      = CAL_RESET;
      filter_shift   = SHIFT_RESET;
      restart_offset = RESTART_RESET;
      offset_start   = OSTART_RESET;
      dc_offset      = longint'(offset_start) << OFFSET_FRAC;
      square_sum     = 0;
      sample_count   = '0;
    endfunction

    function void set_register(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      case (addr)
        REG_WINDOW_LENGTH:  window_length  = data[WLEN_W-1:0];
        REG_CAL_RATIO:      cal_ratio      = data[CAL_W-1:0];
        REG_FILTER_SHIFT:   filter_shift   = data[SHIFT_W-1:0];
        REG_RESTART_OFFSET: restart_offset = data[0];
        REG_OFFSET_START:   offset_start   = data[OSTART_W-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned root;
      longint unsigned probe;
      root  = 0;
      probe = 64'h4000_0000_0000_0000;
      while (probe > x) probe >>= 2;
      while (probe != 0) begin
        if (x >= root + probe) begin
          x    -= root + probe;
          root  = (root >> 1) + probe;
        end else begin
          root >>= 1;
        end
        probe >>= 2;
      end
      return root;
    endfunction

    // one accepted sample: low-pass the offset, accumulate, close the window
    function void take_sample(logic [SAMPLE_BITS-1:0] sample);
      longint          scaled;
      longint          q4;
      longint unsigned mag;
      longint unsigned mean;
      longint unsigned prod;
      irms_word_t      word;
      samples_seen++;
      if (sample_count == 0 && restart_offset)
        dc_offset = longint'(offset_start) << OFFSET_FRAC;
      scaled     = longint'(sample) << OFFSET_FRAC;
      dc_offset += (scaled - dc_offset) >>> filter_shift;
      q4         = (scaled - dc_offset) >>> Q4_SHIFT;
      mag        = (q4 < 0) ? -q4 : q4;
      square_sum += mag * mag;
      sample_count++;
      if (sample_count < window_length && sample_count != '1) return;
      mean           = square_sum / sample_count;
      prod           = (int_sqrt(mean << ROOT_PAD) * cal_ratio) >> CAL_FRAC;
      word.saturated = prod > 64'hFFFF_FFFF;
      word.irms      = word.saturated ? '1 : prod[IRMS_W-1:0];
      irms_expected.push_back(word);
      windows_closed++;
      if (word.saturated) saturated_seen++;
      square_sum   = 0;
      sample_count = '0;
    endfunction

    function int pending();
      return irms_expected.size();
    endfunction

    task report(string what, logic [IRMS_W-1:0] want, logic [IRMS_W-1:0] got);
      errors++;
      $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    task check_irms(logic [IRMS_W-1:0] irms, logic saturated);
      irms_word_t want;
      if (irms_expected.size() == 0) begin
        report("unexpected result word", '0, irms);
        return;
      end
      want = irms_expected.pop_front();
      if (irms !== want.irms) report("irms", want.irms, irms);
      if (saturated !== want.saturated)
        report("saturated", IRMS_W'(want.saturated), IRMS_W'(saturated));
    endtask
  endclass

  // clock and dut ports, all known from time zero
  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  wire                    in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // sample[11:0], zero pad
  wire                    out_tvalid;
  logic                   out_tready = 1'b0;
  wire  [OUT_TDATA_W-1:0] out_tdata;         // irms[31:0]
  wire  [0:0]             out_tuser;         // saturated
  logic                   cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  // idling knobs: sender idle chance is used by the stimulus process only,
  // receiver stall chance and hold-off requests go through nonblocking writes
  int idle_pct      = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int settings_made = 0;

  irms_scoreboard sb = new();

  rms_current_dc_removed_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, or a long hold-off counted here when requested
  always @(posedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served <= holds_served + 1;
      hold_left    <= HOLD_CYCLES;
      out_tready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitors and watchdog; values read here are the ones before this edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_irms(out_tdata[IRMS_W-1:0], out_tuser[0]);
    if (rst_n && in_tvalid && in_tready)
      sb.take_sample(in_tdata[SAMPLE_BITS-1:0]);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[%0t] no word moved for %0d cycles, %0d results still pending",
               $realtime, QUIET_LIMIT, sb.pending());
      $display("** rms_current_dc_removed_core: FAILED **");
      $finish;
    end
  end

  // one register write, cfg_we left high for a following write
  task automatic write_one(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_register(addr, data);
  endtask

  // full register setting, only while the block is idle
  task automatic program_regs(input logic [WLEN_W-1:0] wlen, input logic [CAL_W-1:0] cal,
                              input logic [SHIFT_W-1:0] shift, input logic restart,
                              input logic [OSTART_W-1:0] ostart);
    write_one(REG_WINDOW_LENGTH, CFG_DATA_W'(wlen));
    write_one(REG_CAL_RATIO, CFG_DATA_W'(cal));
    write_one(REG_FILTER_SHIFT, CFG_DATA_W'(shift));
    write_one(REG_RESTART_OFFSET, CFG_DATA_W'(restart));
    write_one(REG_OFFSET_START, CFG_DATA_W'(ostart));
    cfg_we <= 1'b0;
    settings_made++;
  endtask

  // offer one sample word, with random idle cycles ahead of it
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] sample);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(sample);
    do @(posedge clk); while (!in_tready);
  endtask

  // stop offering, wait for every expected result, then let the front end settle
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int sender, input int receiver);
    idle_pct  = sender;
    stall_pct <= receiver;
  endtask

  // full-range noise, a band around the offset start, and the two rails
  function automatic logic [SAMPLE_BITS-1:0] pick_sample(input logic [OSTART_W-1:0] centre);
    int kind;
    int value;
    kind = $urandom_range(9);
    if (kind < 4) return SAMPLE_BITS'($urandom_range(SAMPLE_MAX));
    if (kind == 8) return '0;
    if (kind == 9) return SAMPLE_BITS'(SAMPLE_MAX);
    value = int'(centre) + int'($urandom_range(1600)) - 800;
    if (value < 0) value = 0;
    if (value > SAMPLE_MAX) value = SAMPLE_MAX;
    return SAMPLE_BITS'(value);
  endfunction

  initial begin : stimulus
    logic [WLEN_W-1:0]   wlen;
    logic [CAL_W-1:0]    cal;
    logic [SHIFT_W-1:0]  shift;
    logic [OSTART_W-1:0] ostart;
    logic                restart;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_idling(0, 0);

    // rails in a short window, default filter
    program_regs(16'd4, CAL_RESET, SHIFT_RESET, 1'b1, OSTART_RESET);
    send_sample(0);
    send_sample(SAMPLE_BITS'(SAMPLE_MAX));
    send_sample(0);
    send_sample(SAMPLE_BITS'(SAMPLE_MAX));
    drain_results();

    // zero window length acts as one, zero shift makes the offset follow at once
    program_regs(16'd0, 32'h0100_0000, 4'd0, 1'b0, 12'd2048);
    send_sample(12'd2048);
    send_sample(SAMPLE_BITS'(SAMPLE_MAX));
    send_sample(0);
    send_sample(12'd1234);
    drain_results();

    // largest gain with a slow filter starting at zero clips the result
    program_regs(16'd2, 32'hFFFF_FFFF, 4'd15, 1'b1, 12'd0);
    send_sample(SAMPLE_BITS'(SAMPLE_MAX));
    send_sample(SAMPLE_BITS'(SAMPLE_MAX));
    send_sample(0);
    send_sample(0);
    drain_results();

    // zero gain, offset start at the top rail
    program_regs(16'd2, 32'd0, SHIFT_RESET, 1'b1, 12'(SAMPLE_MAX));
    send_sample(0);
    send_sample(12'd100);
    drain_results();

    // window shortened below the running count closes on the next sample
    program_regs(16'd6, CAL_RESET, 4'd1, 1'b0, 12'(SAMPLE_MAX));
    send_sample(0);
    send_sample(SAMPLE_BITS'(SAMPLE_MAX));
    send_sample(12'd2000);
    drain_results();
    program_regs(16'd2, CAL_RESET, 4'd1, 1'b0, 12'(SAMPLE_MAX));
    send_sample(12'd3000);
    drain_results();

    // random phases, cycling through the idling modes
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase % 4)
        0:       set_idling(0, 0);
        1:       set_idling(46, 0);
        2:       set_idling(0, 46);
        default: set_idling(7, 7);
      endcase
      wlen = WLEN_W'($urandom_range(24, 1));
      if (phase == 2 || $urandom_range(4) == 0) wlen = 16'd1;
      case ($urandom_range(5))
        0:       cal = '0;
        1:       cal = '1;
        2:       cal = CAL_RESET;
        default: cal = $urandom;
      endcase
      shift   = SHIFT_W'($urandom_range(15));
      restart = 1'($urandom_range(1));
      ostart  = OSTART_W'($urandom_range(SAMPLE_MAX));
      program_regs(wlen, cal, shift, restart, ostart);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // long hold-off with one result per word: the block fills and stalls its input
        if (phase == 2 && n == 8) hold_requests <= hold_requests + 1;
        // sender pause until every result is out
        if (phase == 5 && n == 25) drain_results();
        send_sample(pick_sample(sb.offset_start));
      end
      drain_results();
    end

    $display("run covered %0d samples and %0d windows (%0d clipped) over %0d register settings",
             sb.samples_seen, sb.windows_closed, sb.saturated_seen, settings_made);
    $display("idling modes none, sender, receiver and both; one long hold-off and one drain pause");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** rms_current_dc_removed_core: PASSED **");
    end else begin
      $display("** rms_current_dc_removed_core: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
